>>> hw/rtl/gb3_pkg.sv
`timescale 1ns / 1ps
package gb3_pkg;

  localparam int PIX_W          = 16;
  localparam int SUM_W          = 20;
  localparam int POS_W          = 10;
  localparam int CFG_W          = 11;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int MIN_SIZE       = 3;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(10);

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CFG_W-1:0] size_t;

endpackage

>>> hw/rtl/gb3_ram.sv
`timescale 1ns / 1ps
module gb3_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/gaussian_blur_3x3_stream.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_pixel
// out       out_valid / out_ready  out_blurred, out_row, out_col, out_last_of_frame
// cfg       APB write/read         cfg_paddr, cfg_pwdata, cfg_prdata
//
// One pixel per cycle sustained while the output is not stalled; a taken pixel is registered in the
// window stage, the line-store read being registered along with it, and then in the result register.
// Both line stores share one RAM, read at accept and written as the pixel leaves the window stage.
// Reset is synchronous; line stores are not cleared, so no clearing pass is needed.
// A stalled result holds the output register; one more pixel waits behind it.
module gaussian_blur_3x3_stream #(
  parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gb3_pkg::pix_t                   in_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gb3_pkg::sum_t                   out_blurred,
  output gb3_pkg::pos_t                   out_row,
  output gb3_pkg::pos_t                   out_col,
  output logic                            out_last_of_frame,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [gb3_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [gb3_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [gb3_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import gb3_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WCW  = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
  localparam int HCW  = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);
  localparam int RAMW = 2 * PIX_W;

  size_t width_r, height_r;
  logic  cfg_wr;

  logic [WCW-1:0] width_ext, width_clamp;
  logic [HCW-1:0] height_ext, height_clamp;
  logic [AW-1:0]  col_last;
  logic [RW-1:0]  row_last;

  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic          valid_b_r;
  pix_t          pix_b_r;
  logic [AW-1:0] col_b_r;
  logic          prod_b_r;
  pos_t          row_b_r, colo_b_r;
  logic          last_b_r;

  pix_t win_r [6];
  pix_t top, mid;
  sum_t sum;

  logic            acc_in, b_adv;
  logic [RAMW-1:0] ram_rdata;

  logic out_valid_r;
  sum_t blurred_r;
  pos_t out_row_r, out_col_r;
  logic last_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_IMAGE_WIDTH:  cfg_prdata = APB_DATA_W'(width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = APB_DATA_W'(height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // clamp frame size
  always_comb begin
    width_ext  = WCW'(width_r);
    height_ext = HCW'(height_r);
    if (width_ext < WCW'(MIN_SIZE)) begin
      width_clamp = WCW'(MIN_SIZE);
    end else if (width_ext > WCW'(MAX_WIDTH)) begin
      width_clamp = WCW'(MAX_WIDTH);
    end else begin
      width_clamp = width_ext;
    end
    if (height_ext < HCW'(MIN_SIZE)) begin
      height_clamp = HCW'(MIN_SIZE);
    end else if (height_ext > HCW'(MAX_HEIGHT)) begin
      height_clamp = HCW'(MAX_HEIGHT);
    end else begin
      height_clamp = height_ext;
    end
    col_last = AW'(width_clamp - WCW'(1));
    row_last = RW'(height_clamp - HCW'(1));
  end

  // handshake
  assign b_adv    = valid_b_r && (!prod_b_r || !out_valid_r || out_ready);
  assign in_ready = !valid_b_r || b_adv;
  assign acc_in   = in_valid && in_ready;

  // position counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc_in) begin
      if (col_r == col_last) begin
        col_nxt = '0;
        row_nxt = (row_r == row_last) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores: upper in the high half, lower in the low half
  gb3_ram #(
    .DATA_W (RAMW),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (b_adv),
    .waddr (col_b_r),
    .wdata ({mid, pix_b_r}),
    .re    (acc_in),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign top = ram_rdata[RAMW-1:PIX_W];
  assign mid = ram_rdata[PIX_W-1:0];

  // window stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (acc_in) begin
      valid_b_r <= 1'b1;
    end else if (b_adv) begin
      valid_b_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      pix_b_r  <= in_pixel;
      col_b_r  <= col_r;
      prod_b_r <= (row_r >= RW'(2)) && (col_r >= AW'(2));
      row_b_r  <= POS_W'(row_r - RW'(2));
      colo_b_r <= POS_W'(col_r - AW'(2));
      last_b_r <= (row_r == row_last) && (col_r == col_last);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (b_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= pix_b_r;
    end
  end

  assign sum = SUM_W'(win_r[0]) + (SUM_W'(win_r[1]) << 1) + SUM_W'(win_r[2])
             + (SUM_W'(win_r[3]) << 1) + (SUM_W'(win_r[4]) << 2) + (SUM_W'(win_r[5]) << 1)
             + SUM_W'(top) + (SUM_W'(mid) << 1) + SUM_W'(pix_b_r);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv && prod_b_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && prod_b_r) begin
      blurred_r <= sum;
      out_row_r <= row_b_r;
      out_col_r <= colo_b_r;
      last_r    <= last_b_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_blurred       = blurred_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_last_of_frame = last_r;

endmodule
